[hdl/tts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  // Field and datapath widths
  localparam int TIME_W     = 32;
  localparam int LOOP_W     = 16;
  localparam int LC_W       = 17;
  localparam int RATE_W     = 16;
  localparam int RATE_FRAC  = 8;
  localparam int FLAG_W     = 4;
  localparam int DELTA_W    = 24;
  localparam int PROG_W     = 17;
  localparam int CMD_W      = 3;
  localparam int EV_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = DELTA_W + RATE_W;
  localparam int DIV_STEPS  = PROG_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CMP_W      = ((LOOP_W > LC_W - 1) ? LOOP_W : LC_W - 1) + 1;

  // Register defaults
  localparam logic [TIME_W-1:0] DEF_DURATION   = TIME_W'(65536);
  localparam logic [TIME_W-1:0] DEF_DELAY      = '0;
  localparam logic [LC_W-1:0]   DEF_LOOP_COUNT = LC_W'(1);
  localparam logic [RATE_W-1:0] DEF_RATE_SCALE = RATE_W'(256);
  localparam logic [FLAG_W-1:0] DEF_MODE_FLAGS = FLAG_W'(10);

  // Mode flag bits
  localparam int FLAG_PINGPONG    = 0;
  localparam int FLAG_AUTOSTOP    = 1;
  localparam int FLAG_TICK_PAUSED = 2;
  localparam int FLAG_DILATED     = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS  = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_PAUSE   = 3'd3,
    CMD_UNPAUSE = 3'd4,
    CMD_DESTROY = 3'd5,
    CMD_INIT    = 3'd6
  } cmd_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE = 2'd0,
    EV_LOOP = 2'd1,
    EV_TURN = 2'd2,
    EV_DONE = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_LOOP  = 2'd2,
    KIND_TURN  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DELAY,
    ST_MOVE,
    ST_CLAMP,
    ST_DIV,
    ST_END,
    ST_OUT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic              flag;   // carry on add, borrow on subtract
    logic [TIME_W:0]   value;
  } alu_res_t;

  typedef struct packed {
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] start_delay;
    logic [TIME_W-1:0] loop_delay;
    logic [TIME_W-1:0] turn_delay;
    logic [LC_W-1:0]   loop_count;
    logic [RATE_W-1:0] rate_scale;
    logic [FLAG_W-1:0] mode_flags;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DELTA_W-1:0] delta_raw;
    logic [DELTA_W-1:0] delta_dilated;
    logic               host_paused;
  } in_item_t;

  typedef struct packed {
    logic               progress_valid;
    logic [PROG_W-1:0]  progress;
    logic [TIME_W-1:0]  position;
    logic [EV_W-1:0]    event_res;
    logic               is_active;
    logic               is_paused;
    logic               is_reverse;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/tween_timeline_sequencer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Tween timeline sequencer: one timeline driven by commands.
// Input channel (in_valid / in_stall / in_data): one request per command
// (tick, start, restart, pause, unpause, destroy, init). Every request gives
// exactly one result on the output channel (out_valid / out_stall / out_data).
// Configuration: cfg_we writes cfg_wdata into register cfg_idx at the clock
// edge; write only while no request is in flight.
// A tick that moves the position passes decode, multiply, move, clamp, the
// 17 divider steps, end handling and output; a tick that only counts down a
// delay passes decode, multiply, delay countdown and output; a held-off tick
// and other commands pass decode and output.
// The restoring divider for progress runs on the shared adder/subtractor; one
// request is in work at a time, so a new request is accepted only after the
// result of the last one has moved to the output register.
// A finished result waits in the output register; the next request can be
// accepted while it waits, but its own result holds until the register frees.
// While out_stall is high, out_data holds and in_stall stays high once the
// following result is ready.
// Reset (rst_n low, synchronous) loads register defaults, clears the timeline
// state and empties the output register.
module tween_timeline_sequencer_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tts_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tts_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  tts_pkg::cfg_t      cfg_r, cfg_nxt;
  logic               out_valid_r, out_valid_nxt;
  tts_pkg::out_item_t out_data_r, out_data_nxt;

  logic               busy;
  logic               init_regs;
  logic               res_valid;
  tts_pkg::out_item_t res;
  logic               out_free;
  logic               in_take;

  assign in_take  = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  tts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_take),
    .item      (in_data),
    .cfg       (cfg_r),
    .out_free  (out_free),
    .busy      (busy),
    .init_regs (init_regs),
    .res_valid (res_valid),
    .res       (res)
  );

  // Register file: host writes, init restores all but duration
  always_comb begin
    cfg_nxt = cfg_r;
    if (init_regs) begin
      cfg_nxt.start_delay = tts_pkg::DEF_DELAY;
      cfg_nxt.loop_delay  = tts_pkg::DEF_DELAY;
      cfg_nxt.turn_delay  = tts_pkg::DEF_DELAY;
      cfg_nxt.loop_count  = tts_pkg::DEF_LOOP_COUNT;
      cfg_nxt.rate_scale  = tts_pkg::DEF_RATE_SCALE;
      cfg_nxt.mode_flags  = tts_pkg::DEF_MODE_FLAGS;
    end else if (cfg_we) begin
      case (cfg_idx)
        tts_pkg::REG_DURATION:    cfg_nxt.duration    = cfg_wdata[tts_pkg::TIME_W-1:0];
        tts_pkg::REG_START_DELAY: cfg_nxt.start_delay = cfg_wdata[tts_pkg::TIME_W-1:0];
        tts_pkg::REG_LOOP_DELAY:  cfg_nxt.loop_delay  = cfg_wdata[tts_pkg::TIME_W-1:0];
        tts_pkg::REG_TURN_DELAY:  cfg_nxt.turn_delay  = cfg_wdata[tts_pkg::TIME_W-1:0];
        tts_pkg::REG_LOOP_COUNT:  cfg_nxt.loop_count  = cfg_wdata[tts_pkg::LC_W-1:0];
        tts_pkg::REG_RATE_SCALE:  cfg_nxt.rate_scale  = cfg_wdata[tts_pkg::RATE_W-1:0];
        tts_pkg::REG_MODE_FLAGS:  cfg_nxt.mode_flags  = cfg_wdata[tts_pkg::FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duration    <= tts_pkg::DEF_DURATION;
      cfg_r.start_delay <= tts_pkg::DEF_DELAY;
      cfg_r.loop_delay  <= tts_pkg::DEF_DELAY;
      cfg_r.turn_delay  <= tts_pkg::DEF_DELAY;
      cfg_r.loop_count  <= tts_pkg::DEF_LOOP_COUNT;
      cfg_r.rate_scale  <= tts_pkg::DEF_RATE_SCALE;
      cfg_r.mode_flags  <= tts_pkg::DEF_MODE_FLAGS;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r             <= cfg_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hdl/tts_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module tts_alu (
  input  wire tts_pkg::alu_op_t             op,
  input  wire logic [tts_pkg::TIME_W:0]     a,
  input  wire logic [tts_pkg::TIME_W:0]     b,
  output tts_pkg::alu_res_t                 res
);

  logic [tts_pkg::TIME_W+1:0] sum;

  // Shared adder/subtractor with carry or borrow out
  always_comb begin
    case (op)
      tts_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      tts_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default:          sum = {1'b0, a};
    endcase
    res.flag  = sum[tts_pkg::TIME_W+1];
    res.value = sum[tts_pkg::TIME_W:0];
  end

endmodule

`default_nettype wire

[hdl/tts_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module tts_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire tts_pkg::in_item_t   item,
  input  wire tts_pkg::cfg_t       cfg,
  input  wire logic                out_free,
  output logic                     busy,
  output logic                     init_regs,
  output logic                     res_valid,
  output tts_pkg::out_item_t       res
);

  localparam int TW = tts_pkg::TIME_W;

  tts_pkg::state_t state_r, state_nxt;

  // Captured request
  tts_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [tts_pkg::DELTA_W-1:0]    delta_r, delta_nxt;
  logic                           hostp_r, hostp_nxt;

  // Timeline state
  logic [TW-1:0]                  pos_r, pos_nxt;
  logic [TW-1:0]                  delay_r, delay_nxt;
  logic                           rev_r, rev_nxt;
  logic [tts_pkg::LOOP_W-1:0]     loops_r, loops_nxt;
  logic                           active_r, active_nxt;
  logic                           paused_r, paused_nxt;
  tts_pkg::kind_t                 kind_r, kind_nxt;

  // Work registers
  logic [TW-1:0]                  dt_r, dt_nxt;
  logic [TW:0]                    tmp_r, tmp_nxt;
  logic [TW:0]                    rem_r, rem_nxt;
  logic [tts_pkg::PROG_W-1:0]     q_r, q_nxt;
  logic [tts_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TW-1:0]                  shown_r, shown_nxt;
  logic                           valid_r, valid_nxt;
  tts_pkg::ev_t                   ev_r, ev_nxt;

  // Shared unit
  tts_pkg::alu_op_t               alu_op;
  logic [TW:0]                    alu_a;
  logic [TW:0]                    alu_b;
  tts_pkg::alu_res_t              alu_res;

  logic [TW-1:0]                  dur;
  logic                           gated;
  logic [tts_pkg::PROD_W-1:0]     prod;
  logic [TW-1:0]                  dt_sat;
  logic [TW-1:0]                  clamp_pos;
  logic [tts_pkg::LOOP_W-1:0]     loops_inc;
  logic                           more_loops;
  logic                           at_end;

  tts_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Zero duration counts as one unit
  assign dur = (cfg.duration == '0) ? TW'(1) : cfg.duration;

  assign gated = (paused_r || !active_r || hostp_r) &&
                 !cfg.mode_flags[tts_pkg::FLAG_TICK_PAUSED];

  // Scale the delta by the Q8.8 rate and saturate to the time width
  assign prod = tts_pkg::PROD_W'(delta_r) * tts_pkg::PROD_W'(cfg.rate_scale);
  assign dt_sat = (|(prod >> (tts_pkg::RATE_FRAC + TW))) ? '1
                                                          : prod[tts_pkg::RATE_FRAC +: TW];

  // Loop bookkeeping: saturating count, negative loop_count means endless
  assign loops_inc  = (&loops_r) ? loops_r : loops_r + 1'b1;
  assign more_loops = cfg.loop_count[tts_pkg::LC_W-1] ||
                      (tts_pkg::CMP_W'(loops_inc) <
                       tts_pkg::CMP_W'(cfg.loop_count[tts_pkg::LC_W-2:0]));
  assign at_end     = rev_r ? (pos_r == '0) : (pos_r == dur);

  assign clamp_pos = (!alu_res.flag && (alu_res.value != '0)) ? dur : tmp_r[TW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tts_pkg::ST_IDLE:   if (start) state_nxt = tts_pkg::ST_DECODE;
      tts_pkg::ST_DECODE: begin
        if (cmd_r == tts_pkg::CMD_TICK && !gated) state_nxt = tts_pkg::ST_MUL;
        else state_nxt = tts_pkg::ST_OUT;
      end
      tts_pkg::ST_MUL: begin
        if (delay_r != '0) state_nxt = tts_pkg::ST_DELAY;
        else state_nxt = tts_pkg::ST_MOVE;
      end
      tts_pkg::ST_DELAY:  state_nxt = tts_pkg::ST_OUT;
      tts_pkg::ST_MOVE:   state_nxt = tts_pkg::ST_CLAMP;
      tts_pkg::ST_CLAMP:  state_nxt = tts_pkg::ST_DIV;
      tts_pkg::ST_DIV:    if (cnt_r == '0) state_nxt = tts_pkg::ST_END;
      tts_pkg::ST_END:    state_nxt = tts_pkg::ST_OUT;
      tts_pkg::ST_OUT:    if (out_free) state_nxt = tts_pkg::ST_IDLE;
      default:            state_nxt = tts_pkg::ST_IDLE;
    endcase
  end

  // Datapath and state updates
  always_comb begin
    cmd_nxt    = cmd_r;
    delta_nxt  = delta_r;
    hostp_nxt  = hostp_r;
    pos_nxt    = pos_r;
    delay_nxt  = delay_r;
    rev_nxt    = rev_r;
    loops_nxt  = loops_r;
    active_nxt = active_r;
    paused_nxt = paused_r;
    kind_nxt   = kind_r;
    dt_nxt     = dt_r;
    tmp_nxt    = tmp_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    shown_nxt  = shown_r;
    valid_nxt  = valid_r;
    ev_nxt     = ev_r;
    alu_op     = tts_pkg::ALU_SUB;
    alu_a      = tmp_r;
    alu_b      = {1'b0, dur};

    case (state_r)
      tts_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt   = tts_pkg::cmd_t'(item.command);
          delta_nxt = cfg.mode_flags[tts_pkg::FLAG_DILATED] ? item.delta_dilated
                                                            : item.delta_raw;
          hostp_nxt = item.host_paused;
        end
      end

      tts_pkg::ST_DECODE: begin
        valid_nxt = 1'b0;
        ev_nxt    = tts_pkg::EV_NONE;
        case (cmd_r)
          tts_pkg::CMD_TICK: ;
          tts_pkg::CMD_START: begin
            delay_nxt = cfg.start_delay;
            kind_nxt  = (cfg.start_delay != '0) ? tts_pkg::KIND_START : tts_pkg::KIND_NONE;
          end
          tts_pkg::CMD_RESTART: begin
            if (active_r) begin
              pos_nxt    = '0;
              rev_nxt    = 1'b0;
              loops_nxt  = '0;
              paused_nxt = 1'b0;
              delay_nxt  = cfg.start_delay;
              kind_nxt   = (cfg.start_delay != '0) ? tts_pkg::KIND_START
                                                   : tts_pkg::KIND_NONE;
            end
          end
          tts_pkg::CMD_PAUSE:   paused_nxt = 1'b1;
          tts_pkg::CMD_UNPAUSE: paused_nxt = 1'b0;
          tts_pkg::CMD_DESTROY: active_nxt = 1'b0;
          tts_pkg::CMD_INIT: begin
            pos_nxt    = '0;
            delay_nxt  = '0;
            rev_nxt    = 1'b0;
            loops_nxt  = '0;
            active_nxt = 1'b1;
            paused_nxt = 1'b0;
            kind_nxt   = tts_pkg::KIND_NONE;
          end
          default: ;
        endcase
      end

      tts_pkg::ST_MUL: dt_nxt = dt_sat;

      // Count down the pending delay; surplus time is dropped
      tts_pkg::ST_DELAY: begin
        alu_a = {1'b0, delay_r};
        alu_b = {1'b0, dt_r};
        if (alu_res.flag || alu_res.value == '0) begin
          delay_nxt = '0;
          kind_nxt  = tts_pkg::KIND_NONE;
          case (kind_r)
            tts_pkg::KIND_LOOP: ev_nxt = tts_pkg::EV_LOOP;
            tts_pkg::KIND_TURN: ev_nxt = tts_pkg::EV_TURN;
            default:            ev_nxt = tts_pkg::EV_NONE;
          endcase
        end else begin
          delay_nxt = alu_res.value[TW-1:0];
        end
      end

      // Advance or rewind the position
      tts_pkg::ST_MOVE: begin
        alu_a  = {1'b0, pos_r};
        alu_b  = {1'b0, dt_r};
        alu_op = rev_r ? tts_pkg::ALU_SUB : tts_pkg::ALU_ADD;
        if (rev_r && alu_res.flag) tmp_nxt = '0;
        else tmp_nxt = alu_res.value;
      end

      // Clamp to the duration and seed the divider
      tts_pkg::ST_CLAMP: begin
        alu_a     = tmp_r;
        pos_nxt   = clamp_pos;
        shown_nxt = clamp_pos;
        valid_nxt = 1'b1;
        rem_nxt   = {1'b0, clamp_pos};
        q_nxt     = '0;
        cnt_nxt   = tts_pkg::CNT_W'(tts_pkg::DIV_STEPS - 1);
      end

      // One quotient bit per cycle, restoring
      tts_pkg::ST_DIV: begin
        alu_a = rem_r;
        q_nxt = {q_r[tts_pkg::PROG_W-2:0], !alu_res.flag};
        if (!alu_res.flag) rem_nxt = {alu_res.value[TW-1:0], 1'b0};
        else rem_nxt = {rem_r[TW-1:0], 1'b0};
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
      end

      // Handle ping-pong turn, loop restart or completion
      tts_pkg::ST_END: begin
        if (at_end) begin
          if (!rev_r && cfg.mode_flags[tts_pkg::FLAG_PINGPONG]) begin
            rev_nxt   = 1'b1;
            delay_nxt = cfg.turn_delay;
            if (cfg.turn_delay != '0) kind_nxt = tts_pkg::KIND_TURN;
            else ev_nxt = tts_pkg::EV_TURN;
          end else begin
            loops_nxt = loops_inc;
            if (more_loops) begin
              delay_nxt = cfg.loop_delay;
              pos_nxt   = '0;
              rev_nxt   = 1'b0;
              if (cfg.loop_delay != '0) kind_nxt = tts_pkg::KIND_LOOP;
              else ev_nxt = tts_pkg::EV_LOOP;
            end else begin
              if (cfg.mode_flags[tts_pkg::FLAG_AUTOSTOP]) active_nxt = 1'b0;
              else paused_nxt = 1'b1;
              ev_nxt = tts_pkg::EV_DONE;
            end
          end
        end
      end

      default: ;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    busy               = (state_r != tts_pkg::ST_IDLE);
    init_regs          = (state_r == tts_pkg::ST_DECODE) && (cmd_r == tts_pkg::CMD_INIT);
    res_valid          = (state_r == tts_pkg::ST_OUT) && out_free;
    res.progress_valid = valid_r;
    res.progress       = valid_r ? q_r : '0;
    res.position       = valid_r ? shown_r : pos_r;
    res.event_res      = ev_r;
    res.is_active      = active_r;
    res.is_paused      = paused_r;
    res.is_reverse     = rev_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tts_pkg::ST_IDLE;
      pos_r    <= '0;
      delay_r  <= '0;
      rev_r    <= 1'b0;
      loops_r  <= '0;
      active_r <= 1'b1;
      paused_r <= 1'b0;
      kind_r   <= tts_pkg::KIND_NONE;
      valid_r  <= 1'b0;
      ev_r     <= tts_pkg::EV_NONE;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      delay_r  <= delay_nxt;
      rev_r    <= rev_nxt;
      loops_r  <= loops_nxt;
      active_r <= active_nxt;
      paused_r <= paused_nxt;
      kind_r   <= kind_nxt;
      valid_r  <= valid_nxt;
      ev_r     <= ev_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    delta_r <= delta_nxt;
    hostp_r <= hostp_nxt;
    dt_r    <= dt_nxt;
    tmp_r   <= tmp_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    shown_r <= shown_nxt;
  end

endmodule

`default_nettype wire

[hdl/tts_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tts_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tts_pkg::out_item_t  out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Take one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in work");

  // Report no progress without a position update, and never above one
  a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.progress_valid ? (out_data.progress <= 17'd65536)
                                           : (out_data.progress == '0)))
    else $error("progress out of range");

  // Stop or pause on completion
  a_done_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == tts_pkg::EV_DONE |->
      !out_data.is_active || out_data.is_paused)
    else $error("completion left timeline running");

  // Empty the output register on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tween_timeline_sequencer_unit tts_checker u_tts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tts_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_GAP       = 5;
  localparam int RANDOM_PHASES = 12;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tween_timeline_sequencer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the timeline: registers and state
  cfg_t              tl_cfg;
  logic [TIME_W-1:0] tl_pos;
  logic [TIME_W-1:0] tl_delay;
  logic              tl_reverse;
  logic              tl_active;
  logic              tl_paused;
  logic [LOOP_W-1:0] tl_loops;
  kind_t             tl_kind;

  out_item_t predicted_reports[$];

  int  errors = 0;
  int  cycle_count = 0;
  int  n_requests = 0;
  int  n_moves = 0;
  int  n_gated = 0;
  int  n_events[4];
  bit  steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Return registers (optionally all but duration) and state to reset values
  function automatic void reset_timeline(input bit keep_duration);
    if (!keep_duration) tl_cfg.duration = DEF_DURATION;
    tl_cfg.start_delay = DEF_DELAY;
    tl_cfg.loop_delay  = DEF_DELAY;
    tl_cfg.turn_delay  = DEF_DELAY;
    tl_cfg.loop_count  = DEF_LOOP_COUNT;
    tl_cfg.rate_scale  = DEF_RATE_SCALE;
    tl_cfg.mode_flags  = DEF_MODE_FLAGS;
    tl_pos     = '0;
    tl_delay   = '0;
    tl_reverse = 1'b0;
    tl_loops   = '0;
    tl_active  = 1'b1;
    tl_paused  = 1'b0;
    tl_kind    = KIND_NONE;
  endfunction

  function automatic void arm_start();
    tl_delay = tl_cfg.start_delay;
    tl_kind  = (tl_delay != 0) ? KIND_START : KIND_NONE;
  endfunction

  // Count a finished loop; restart, or complete by stopping or pausing
  function automatic ev_t finish_loop();
    int lc;
    lc = int'($signed(tl_cfg.loop_count));
    if (tl_loops != '1) tl_loops++;
    if (lc < 0 || int'(tl_loops) < lc) begin
      tl_delay   = tl_cfg.loop_delay;
      tl_pos     = '0;
      tl_reverse = 1'b0;
      if (tl_delay != 0) begin
        tl_kind = KIND_LOOP;
        return EV_NONE;
      end
      return EV_LOOP;
    end
    if (tl_cfg.mode_flags[FLAG_AUTOSTOP]) tl_active = 1'b0;
    else tl_paused = 1'b1;
    return EV_DONE;
  endfunction

  function automatic ev_t begin_turn();
    tl_reverse = 1'b1;
    tl_delay   = tl_cfg.turn_delay;
    if (tl_delay != 0) begin
      tl_kind = KIND_TURN;
      return EV_NONE;
    end
    return EV_TURN;
  endfunction

  // Apply one request to the shadow timeline and build the report it yields
  function automatic out_item_t advance_timeline(input in_item_t req);
    out_item_t          rep;
    ev_t                ev;
    logic [DELTA_W-1:0] delta;
    logic [PROD_W-1:0]  scaled;
    logic [TIME_W-1:0]  dt;
    logic [TIME_W-1:0]  dur;
    logic [TIME_W:0]    next;
    logic [TIME_W+15:0] num;
    rep = '0;
    ev  = EV_NONE;
    case (req.command)
      CMD_TICK: begin
        if ((tl_paused || !tl_active || req.host_paused) &&
            !tl_cfg.mode_flags[FLAG_TICK_PAUSED]) begin
          n_gated++;
        end else begin
          delta  = tl_cfg.mode_flags[FLAG_DILATED] ? req.delta_dilated : req.delta_raw;
          scaled = (PROD_W'(delta) * PROD_W'(tl_cfg.rate_scale)) >> RATE_FRAC;
          // 24 x 16 bits shifted by 8 always fits the time range
          dt = scaled[TIME_W-1:0];
          if (tl_delay != 0) begin
            // Burn the delay; drop any surplus
            if (dt >= tl_delay) begin
              tl_delay = '0;
              if (tl_kind == KIND_LOOP) ev = EV_LOOP;
              else if (tl_kind == KIND_TURN) ev = EV_TURN;
              tl_kind = KIND_NONE;
            end else begin
              tl_delay -= dt;
            end
          end else begin
            dur = (tl_cfg.duration == 0) ? TIME_W'(1) : tl_cfg.duration;
            if (tl_reverse) next = (dt >= tl_pos) ? '0 : {1'b0, tl_pos - dt};
            else next = {1'b0, tl_pos} + dt;
            if (next > dur) next = dur;
            tl_pos = next[TIME_W-1:0];
            num = {tl_pos, 16'h0000};
            rep.progress_valid = 1'b1;
            rep.progress       = PROG_W'(num / dur);
            rep.position       = tl_pos;
            n_moves++;
            // Handle the ends after the position is reported
            if (tl_reverse) begin
              if (tl_pos == 0) ev = finish_loop();
            end else if (tl_pos >= dur) begin
              if (tl_cfg.mode_flags[FLAG_PINGPONG]) ev = begin_turn();
              else ev = finish_loop();
            end
          end
        end
      end
      CMD_START: arm_start();
      CMD_RESTART: begin
        if (tl_active) begin
          tl_pos     = '0;
          tl_reverse = 1'b0;
          tl_loops   = '0;
          tl_paused  = 1'b0;
          arm_start();
        end
      end
      CMD_PAUSE:   tl_paused = 1'b1;
      CMD_UNPAUSE: tl_paused = 1'b0;
      CMD_DESTROY: tl_active = 1'b0;
      CMD_INIT:    reset_timeline(1'b1);
      default: ;
    endcase
    if (!rep.progress_valid) rep.position = tl_pos;
    rep.event_res  = ev;
    rep.is_active  = tl_active;
    rep.is_paused  = tl_paused;
    rep.is_reverse = tl_reverse;
    n_events[ev]++;
    return rep;
  endfunction

  function automatic in_item_t make_request(input logic [CMD_W-1:0] cmd,
                                            input logic [DELTA_W-1:0] raw,
                                            input logic [DELTA_W-1:0] dilated,
                                            input logic host);
    in_item_t req;
    req.command       = cmd;
    req.delta_raw     = raw;
    req.delta_dilated = dilated;
    req.host_paused   = host;
    return req;
  endfunction

  // Send one request after a random gap (none in steady flow) and record its expected report
  task automatic send_request(input in_item_t req);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted_reports.push_back(advance_timeline(req));
    n_requests++;
    @(negedge clk);
  endtask

  // Hold off until every expected report has arrived
  task automatic await_idle();
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Write every register while the block is idle
  task automatic load_config(input cfg_t c);
    await_idle();
    cfg_write(REG_DURATION, c.duration);
    cfg_write(REG_START_DELAY, c.start_delay);
    cfg_write(REG_LOOP_DELAY, c.loop_delay);
    cfg_write(REG_TURN_DELAY, c.turn_delay);
    cfg_write(REG_LOOP_COUNT, CFG_DATA_W'($signed(c.loop_count)));
    cfg_write(REG_RATE_SCALE, CFG_DATA_W'(c.rate_scale));
    cfg_write(REG_MODE_FLAGS, CFG_DATA_W'(c.mode_flags));
    cfg_we <= 1'b0;
    tl_cfg = c;
  endtask

  function automatic logic [TIME_W-1:0] pick_delay(input logic [TIME_W-1:0] dur);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return '0;
      5, 6, 7, 8:    return $urandom_range(1, (dur > (1 << 24)) ? (1 << 24) : dur);
      default:       return $urandom;
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c.duration = $urandom_range(1, 64);
      4, 5, 6, 7: c.duration = $urandom_range(65, 1 << 20);
      8:          c.duration = $urandom;
      default:    c.duration = $urandom_range(0, 1) ? '0 : '1;
    endcase
    c.start_delay = pick_delay(c.duration);
    c.loop_delay  = pick_delay(c.duration);
    c.turn_delay  = pick_delay(c.duration);
    case ($urandom_range(0, 7))
      0, 1:    c.loop_count = '1;
      2:       c.loop_count = '0;
      3:       c.loop_count = LC_W'(65535);
      4:       c.loop_count = LC_W'($urandom);
      default: c.loop_count = LC_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c.rate_scale = DEF_RATE_SCALE;
      4, 5, 6, 7: c.rate_scale = RATE_W'($urandom_range(16, 1024));
      default:    c.rate_scale = RATE_W'($urandom);
    endcase
    c.mode_flags = FLAG_W'($urandom_range(0, 15));
    return c;
  endfunction

  // Mostly deltas that reach an end within a few ticks, plus full-range noise
  function automatic logic [DELTA_W-1:0] pick_delta(input longint reach);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DELTA_W'($urandom);
      default: return DELTA_W'($urandom_range(0, reach));
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t          req;
    int                pick;
    longint            reach;
    logic [TIME_W-1:0] dur;
    dur   = (tl_cfg.duration == 0) ? TIME_W'(1) : tl_cfg.duration;
    reach = (longint'(dur) << RATE_FRAC) /
            ((tl_cfg.rate_scale == 0) ? 1 : longint'(tl_cfg.rate_scale));
    if (reach > longint'(24'hFFFFFF)) reach = longint'(24'hFFFFFF);
    pick = $urandom_range(0, 99);
    if (pick < 72)      req.command = CMD_TICK;
    else if (pick < 77) req.command = CMD_START;
    else if (pick < 83) req.command = CMD_RESTART;
    else if (pick < 87) req.command = CMD_PAUSE;
    else if (pick < 92) req.command = CMD_UNPAUSE;
    else if (pick < 94) req.command = CMD_DESTROY;
    else if (pick < 98) req.command = CMD_INIT;
    else                req.command = CMD_UNUSED;
    req.delta_raw     = pick_delta(reach);
    req.delta_dilated = pick_delta(reach);
    req.host_paused   = ($urandom_range(0, 9) == 0);
    return req;
  endfunction

  // Every command from reset defaults, gating and the stopped restart
  task automatic test_command_set();
    send_request(make_request(CMD_TICK, 24'hFFFFFF, 24'h000100, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000000, 24'hFFFFFF, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000010, 24'h000010, 1'b0));
    send_request(make_request(CMD_RESTART, '0, '0, 1'b0));
    send_request(make_request(CMD_INIT, '0, '0, 1'b0));
    send_request(make_request(CMD_PAUSE, '0, '0, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000010, 24'h000010, 1'b0));
    send_request(make_request(CMD_UNPAUSE, '0, '0, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000010, 24'h000010, 1'b1));
    send_request(make_request(CMD_START, '0, '0, 1'b0));
    send_request(make_request(CMD_DESTROY, '0, '0, 1'b0));
    send_request(make_request(CMD_UNUSED, 24'h123456, 24'h654321, 1'b1));
  endtask

  // Zero duration, start, turn and loop delays, tick while paused
  task automatic test_delays_and_turns();
    cfg_t c;
    c.duration    = '0;
    c.start_delay = TIME_W'(5);
    c.loop_delay  = TIME_W'(3);
    c.turn_delay  = TIME_W'(2);
    c.loop_count  = LC_W'(2);
    c.rate_scale  = '1;
    c.mode_flags  = '0;
    c.mode_flags[FLAG_PINGPONG]    = 1'b1;
    c.mode_flags[FLAG_TICK_PAUSED] = 1'b1;
    load_config(c);
    send_request(make_request(CMD_START, '0, '0, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000000, 24'h000000, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000001, 24'h000000, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000001, 24'h000000, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000001, 24'h000000, 1'b0));
    send_request(make_request(CMD_PAUSE, '0, '0, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000001, 24'h000000, 1'b0));
    send_request(make_request(CMD_TICK, 24'h000001, 24'h000000, 1'b1));
  endtask

  // Largest times, endless loops, largest deltas and rate
  task automatic test_range_extremes();
    cfg_t c;
    c.duration    = '1;
    c.start_delay = '1;
    c.loop_delay  = '1;
    c.turn_delay  = '1;
    c.loop_count  = '1;
    c.rate_scale  = '1;
    c.mode_flags  = '0;
    c.mode_flags[FLAG_DILATED] = 1'b1;
    load_config(c);
    send_request(make_request(CMD_RESTART, '0, '0, 1'b0));
    repeat (4) send_request(make_request(CMD_TICK, 24'h000000, 24'hFFFFFF, 1'b0));
  endtask

  // Random phases, each under its own register setting
  task automatic test_random_phases();
    cfg_t c;
    int   count;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c = random_config();
      if (p == 0) begin
        c.duration    = TIME_W'(1);
        c.start_delay = '0;
        c.loop_delay  = '0;
        c.turn_delay  = '0;
        c.loop_count  = '0;
        c.rate_scale  = '0;
        c.mode_flags  = '0;
      end else if (p == 1) begin
        c.loop_count = LC_W'(65535);
        c.rate_scale = '1;
        c.mode_flags = '1;
      end
      load_config(c);
      steady_flow = (p == 2) || (p == 7);
      count = (p < 2) ? 40 : 100;
      repeat (count) send_request(random_request());
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin : report_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("progress_valid", want.progress_valid, out_data.progress_valid);
        check_field("progress", want.progress, out_data.progress);
        check_field("position", want.position, out_data.position);
        check_field("event_res", want.event_res, out_data.event_res);
        check_field("is_active", want.is_active, out_data.is_active);
        check_field("is_paused", want.is_paused, out_data.is_paused);
        check_field("is_reverse", want.is_reverse, out_data.is_reverse);
      end
    end
  end

  // Stall the report channel a random number of cycles per report
  initial begin : report_sink
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports outstanding",
               cycle_count, predicted_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    reset_timeline(1'b0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_command_set();
    test_delays_and_turns();
    test_range_extremes();
    test_random_phases();

    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d position updates, %0d ticks held off by pause or stop.",
             n_requests, n_moves, n_gated);
    $display("Saw %0d loop restarts, %0d ping-pong turns, %0d completions; %0d mismatches.",
             n_events[EV_LOOP], n_events[EV_TURN], n_events[EV_DONE], errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
